FILE: design/millisecond_timer_bank_unit_assert.svh
// Assertion macros for the timer bank unit.
`ifndef MILLISECOND_TIMER_BANK_UNIT_ASSERT_SVH
`define MILLISECOND_TIMER_BANK_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MTB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mtb_pkg.sv
package mtb_pkg;

    localparam int NUM_ONESHOT = 8;
    localparam int NUM_CALLS   = 8;
    localparam int COUNT_WIDTH = 16;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int VAL_W   = 16;
    localparam int KIND_W  = 2;
    localparam int SLOT_XW = 7;
    localparam int MAX_RESULTS = 8;
    localparam int EMIT_CW = $clog2(MAX_RESULTS);

    localparam int OS_IW   = (NUM_ONESHOT > 1) ? $clog2(NUM_ONESHOT) : 1;
    localparam int CALL_IW = (NUM_CALLS > 1) ? $clog2(NUM_CALLS) : 1;

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_ONE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_CALL  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_ONE  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOFIRE = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic emit;
        logic advance;
        logic scanning;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic tick_op;
        logic fire_any;
        logic cur_fire;
        logic emit_final;
    } t_stat;

endpackage

FILE: design/mtb_ctrl.sv
module mtb_ctrl
    import mtb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.out_free && i_stat.tick_op && i_stat.fire_any) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.cur_fire && i_stat.out_free && i_stat.emit_final) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_stat.out_free;
                o_cmd.accept   = i_in_valid && i_stat.out_free;
            end
            S_SCAN: begin
                o_cmd.scanning = 1'b1;
                o_cmd.emit     = i_stat.cur_fire && i_stat.out_free;
                o_cmd.advance  = !i_stat.cur_fire || i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: design/mtb_datapath.sv
module mtb_datapath
    import mtb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_delay_value,
    input  logic [VAL_W-1:0]    i_period_value,
    input  logic                i_out_stall,
    output t_stat               o_stat,
    output logic                o_out_valid,
    output logic [KIND_W-1:0]   o_kind,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [VAL_W-1:0]    o_remaining,
    output logic                o_last
);

    logic [COUNT_WIDTH-1:0] r_os_cnt   [NUM_ONESHOT];
    logic [COUNT_WIDTH-1:0] r_call_cnt [NUM_CALLS];
    logic [COUNT_WIDTH-1:0] r_call_per [NUM_CALLS];

    logic [NUM_CALLS-1:0]   r_fire;
    logic [CALL_IW-1:0]     r_idx;
    logic [EMIT_CW-1:0]     r_emit_cnt;

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [SLOT_W-1:0]      r_slot;
    logic [VAL_W-1:0]       r_rem;
    logic                   r_last;

    logic [NUM_CALLS-1:0]   fire_vec;
    logic [SLOT_XW-1:0]     slot_x;
    logic                   os_hit;
    logic                   call_hit;
    logic [COUNT_WIDTH-1:0] dly;
    logic [COUNT_WIDTH-1:0] per;
    logic                   out_load;
    logic                   out_free;

    assign slot_x   = SLOT_XW'(i_slot);
    assign os_hit   = slot_x < SLOT_XW'(NUM_ONESHOT);
    assign call_hit = slot_x < SLOT_XW'(NUM_CALLS);
    assign dly      = COUNT_WIDTH'(i_delay_value);
    assign per      = COUNT_WIDTH'(i_period_value);

    // A call fires on this tick when its count is about to step from one to zero.
    always_comb begin
        for (int i = 0; i < NUM_CALLS; i++) begin
            fire_vec[i] = (r_call_cnt[i] == COUNT_WIDTH'(1));
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (i_cmd.accept && !(i_op == OP_TICK && (|fire_vec))) || i_cmd.emit;

    assign o_stat.out_free   = out_free;
    assign o_stat.tick_op    = (i_op == OP_TICK);
    assign o_stat.fire_any   = |fire_vec;
    assign o_stat.cur_fire   = r_fire[0];
    assign o_stat.emit_final = ((r_fire >> 1) == '0) || (r_emit_cnt == EMIT_CW'(MAX_RESULTS - 1));

    // Timer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ONESHOT; i++) begin
                r_os_cnt[i] <= '0;
            end
            for (int i = 0; i < NUM_CALLS; i++) begin
                r_call_cnt[i] <= '0;
                r_call_per[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            case (i_op)
                OP_TICK: begin
                    for (int i = 0; i < NUM_ONESHOT; i++) begin
                        if (r_os_cnt[i] != '0) begin
                            r_os_cnt[i] <= r_os_cnt[i] - 1'b1;
                        end
                    end
                    for (int i = 0; i < NUM_CALLS; i++) begin
                        if (fire_vec[i]) begin
                            r_call_cnt[i] <= r_call_per[i];
                        end else if (r_call_cnt[i] != '0) begin
                            r_call_cnt[i] <= r_call_cnt[i] - 1'b1;
                        end
                    end
                end
                OP_SET_ONE: begin
                    if (os_hit) begin
                        r_os_cnt[slot_x[OS_IW-1:0]] <= dly;
                    end
                end
                OP_SET_CALL: begin
                    if (call_hit) begin
                        r_call_cnt[slot_x[CALL_IW-1:0]] <= dly;
                        r_call_per[slot_x[CALL_IW-1:0]] <= per;
                    end
                end
                default: ;
            endcase
        end
    end

    // Fired-call walk: one call slot per cycle, pausing at a firing slot while the output is blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire     <= '0;
            r_idx      <= '0;
            r_emit_cnt <= '0;
        end else if (i_cmd.accept && i_op == OP_TICK) begin
            r_fire     <= fire_vec;
            r_idx      <= '0;
            r_emit_cnt <= '0;
        end else begin
            if (i_cmd.advance) begin
                r_fire <= r_fire >> 1;
                r_idx  <= CALL_IW'(r_idx + 1'b1);
            end
            if (i_cmd.emit) begin
                r_emit_cnt <= EMIT_CW'(r_emit_cnt + 1'b1);
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= KIND_FIRED;
            r_slot <= SLOT_W'(r_idx);
            r_rem  <= '0;
            r_last <= o_stat.emit_final;
        end else if (out_load) begin
            r_slot <= i_slot;
            r_rem  <= '0;
            r_last <= 1'b1;
            case (i_op)
                OP_TICK: begin
                    r_kind <= KIND_NOFIRE;
                    r_slot <= '0;
                end
                OP_READ_ONE: begin
                    r_kind <= KIND_READ;
                    if (os_hit) begin
                        r_rem <= VAL_W'(r_os_cnt[slot_x[OS_IW-1:0]]);
                    end
                end
                default: r_kind <= KIND_ACK;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_slot_out  = r_slot;
    assign o_remaining = r_rem;
    assign o_last      = r_last;

endmodule

FILE: design/millisecond_timer_bank_unit.sv
// Bank of one-shot countdown timers and periodic call timers.
// Input channel (i_in_valid / o_in_stall) carries one op word: tick, set a
// one-shot delay, set a call delay and period, or read a one-shot count.
// Output channel (o_out_valid / i_out_stall) returns result words; the
// final word caused by an input carries o_last.
// Set and read ops: one result word, registered one cycle after accept.
// Tick: all counts step in the accept cycle. With no call firing, a single
// "no firing" word follows, registered at accept. Otherwise the call slots
// are walked one per cycle unless the output stalls, emitting a fired word
// for each expiring call in ascending slot order; the walk ends once the
// last firing slot has emitted.
// One op is in flight at a time; input stays stalled during a tick walk.
// When the receiver stalls, the output word holds; the walk steps past
// quiet slots and pauses at the next firing slot until the word drains.
// Reset (synchronous, active low) clears every count and period and
// empties the output register.
module millisecond_timer_bank_unit
    import mtb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_delay_value,
    input  logic [VAL_W-1:0]    i_period_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KIND_W-1:0]   o_kind,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [VAL_W-1:0]    o_remaining,
    output logic                o_last
);

    `include "millisecond_timer_bank_unit_assert.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer: idle / walking fired calls.
    mtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Counts, periods, fire walk and output word register.
    mtb_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_delay_value  (i_delay_value),
        .i_period_value (i_period_value),
        .i_out_stall    (i_out_stall),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_remaining    (o_remaining),
        .o_last         (o_last)
    );

    // Hold off new ops while the output is blocked or a tick walk runs.
    assign o_in_stall = !w_cmd.in_ready;

    // An accepted op always yields a word or a walk on the next cycle.
    `MTB_ASSERT_NEXT(a_accept_progress, i_in_valid && !o_in_stall,
        o_out_valid || w_cmd.scanning, "accepted op produced no result")
    // No new op enters during a tick walk.
    `MTB_ASSERT_IMP(a_walk_blocks_input, w_cmd.scanning, o_in_stall,
        "input accepted during tick walk")
    // A tick without firings is always a single, final word.
    `MTB_ASSERT_IMP(a_nofire_last, o_out_valid && o_kind == KIND_NOFIRE, o_last,
        "no-firing word without last")

endmodule

FILE: sim/timer_bank_checker.sv
`timescale 1ns / 100ps

module timer_bank_checker
    import mtb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [VAL_W-1:0]    i_delay_value,
    input  logic [VAL_W-1:0]    i_period_value,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot_out,
    input  logic [VAL_W-1:0]    i_remaining,
    input  logic                i_last,
    output int                  o_pending,
    output int                  o_mismatches
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  remaining;
        logic              last;
    } t_timer_word;

    logic [COUNT_WIDTH-1:0] oneshot_left [NUM_ONESHOT];
    logic [COUNT_WIDTH-1:0] call_left    [NUM_CALLS];
    logic [COUNT_WIDTH-1:0] call_reload  [NUM_CALLS];

    t_timer_word expected_words [$];
    int          mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_timer_word make_word(input logic [KIND_W-1:0] kind,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [VAL_W-1:0]  remaining,
                                              input logic              last);
        t_timer_word word;
        word.kind      = kind;
        word.slot      = slot;
        word.remaining = remaining;
        word.last      = last;
        return word;
    endfunction

    function automatic void clear_timers();
        for (int i = 0; i < NUM_ONESHOT; i++)
            oneshot_left[i] = '0;
        for (int i = 0; i < NUM_CALLS; i++) begin
            call_left[i]   = '0;
            call_reload[i] = '0;
        end
    endfunction

    // Advance the bank by one op and queue the words it must produce.
    function automatic void predict_timer_op(input logic [OP_W-1:0]   op,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [VAL_W-1:0]  dly,
                                             input logic [VAL_W-1:0]  per);
        logic [NUM_CALLS-1:0] fired_mask;
        int                   top_slot;
        int                   emitted;
        fired_mask = '0;
        top_slot   = -1;
        emitted    = 0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < NUM_ONESHOT; i++)
                    if (oneshot_left[i] != '0)
                        oneshot_left[i] = oneshot_left[i] - 1'b1;
                for (int i = 0; i < NUM_CALLS; i++) begin
                    if (call_left[i] != '0) begin
                        call_left[i] = call_left[i] - 1'b1;
                        if (call_left[i] == '0) begin
                            call_left[i] = call_reload[i];
                            if (emitted < MAX_RESULTS) begin
                                fired_mask[i] = 1'b1;
                                top_slot      = i;
                                emitted++;
                            end
                        end
                    end
                end
                if (top_slot < 0) begin
                    expected_words.push_back(make_word(KIND_NOFIRE, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < NUM_CALLS; i++)
                        if (fired_mask[i])
                            expected_words.push_back(make_word(KIND_FIRED, SLOT_W'(i),
                                                               '0, i == top_slot));
                end
            end
            OP_SET_ONE: begin
                if (slot < NUM_ONESHOT)
                    oneshot_left[slot] = COUNT_WIDTH'(dly);
                expected_words.push_back(make_word(KIND_ACK, slot, '0, 1'b1));
            end
            OP_SET_CALL: begin
                if (slot < NUM_CALLS) begin
                    call_left[slot]   = COUNT_WIDTH'(dly);
                    call_reload[slot] = COUNT_WIDTH'(per);
                end
                expected_words.push_back(make_word(KIND_ACK, slot, '0, 1'b1));
            end
            default: begin
                expected_words.push_back(make_word(KIND_READ, slot,
                    (slot < NUM_ONESHOT) ? VAL_W'(oneshot_left[slot]) : '0, 1'b1));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_timer_word want;
        if (!i_rst_n) begin
            clear_timers();
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_timer_op(i_op, i_slot, i_delay_value, i_period_value);
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d slot %0d",
                                              i_kind, i_slot_out));
                end else begin
                    want = expected_words.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                                                  i_kind, want.kind));
                    if (i_slot_out !== want.slot)
                        report_mismatch($sformatf("slot got %0d want %0d",
                                                  i_slot_out, want.slot));
                    if (i_remaining !== want.remaining)
                        report_mismatch($sformatf("remaining got %0d want %0d",
                                                  i_remaining, want.remaining));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last got %0d want %0d",
                                                  i_last, want.last));
                end
            end
            o_pending <= expected_words.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mtb_pkg::*;

    // Quiet cycles allowed before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 430;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_op           = OP_TICK;
    logic [SLOT_W-1:0]  i_slot         = '0;
    logic [VAL_W-1:0]   i_delay_value  = '0;
    logic [VAL_W-1:0]   i_period_value = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [KIND_W-1:0]  o_kind;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [VAL_W-1:0]   o_remaining;
    logic               o_last;

    int                 pending_words;
    int                 mismatch_total;

    // Set during the stretch where neither side idles at random.
    logic               steady_mode    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    millisecond_timer_bank_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_delay_value  (i_delay_value),
        .i_period_value (i_period_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_remaining    (o_remaining),
        .o_last         (o_last)
    );

    // Predict and compare beside the block; hand back pending and failure counts.
    timer_bank_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_delay_value  (i_delay_value),
        .i_period_value (i_period_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_kind         (o_kind),
        .i_slot_out     (o_slot_out),
        .i_remaining    (o_remaining),
        .i_last         (o_last),
        .o_pending      (pending_words),
        .o_mismatches   (mismatch_total)
    );

    // Receiver: stalls at random about 12 percent of the time, never in steady mode.
    // Stalls land on any phase of a tick walk; the walk pauses at a firing slot while the word is held.
    always @(posedge i_clk) begin
        if (steady_mode)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(0, 99) < 12);
    end

    // Hang detector: end the run when nothing moves on either channel.
    initial begin : hang_watch
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one op word and hold it until the block takes it. Idle first,
    // at random, unless in steady mode. Valid drops only between words.
    task automatic send_word(input logic [OP_W-1:0]   op,
                             input logic [SLOT_W-1:0] slot,
                             input logic [VAL_W-1:0]  dly,
                             input logic [VAL_W-1:0]  per);
        while (!steady_mode && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_slot         <= slot;
        i_delay_value  <= dly;
        i_period_value <= per;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0)
            @(posedge i_clk);
    endtask

    // Mostly short counts so calls fire often; some all-ones and full-range.
    function automatic logic [VAL_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return VAL_W'($urandom_range(0, 6));
        else if (roll < 80)
            return '1;
        else
            return VAL_W'($urandom);
    endfunction

    task automatic send_random_word();
        logic [OP_W-1:0] op;
        int              roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            op = OP_TICK;
        else if (roll < 60)
            op = OP_SET_ONE;
        else if (roll < 80)
            op = OP_SET_CALL;
        else
            op = OP_READ_ONE;
        // Fields unused by the op still carry random content.
        send_word(op, SLOT_W'($urandom), pick_count(), pick_count());
    endtask

    initial begin
        // Hold reset, then release it for good.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a tick on an empty bank gives the single no-firing word.
        send_word(OP_TICK, '0, 16'hA5A5, 16'h5A5A);
        send_word(OP_READ_ONE, '0, '0, '0);
        // One-shot extremes: full count, and a count that stops at zero.
        send_word(OP_SET_ONE, 3'd0, 16'hFFFF, '0);
        send_word(OP_SET_ONE, 3'd7, 16'd1, 16'hFFFF);
        send_word(OP_READ_ONE, 3'd0, '0, '0);
        send_word(OP_READ_ONE, 3'd7, '0, '0);
        send_word(OP_TICK, '0, '0, '0);
        send_word(OP_TICK, '0, '0, '0);
        send_word(OP_READ_ONE, 3'd7, '0, '0);
        send_word(OP_READ_ONE, 3'd0, '0, '0);
        // Arm every call to expire on the next tick; slot 0 has period zero
        // and must go inactive after it fires.
        for (int s = 0; s < NUM_CALLS; s++)
            send_word(OP_SET_CALL, SLOT_W'(s), 16'd1, VAL_W'(s));
        // Let everything settle before the largest tick, so it starts idle.
        wait_drained();
        send_word(OP_TICK, '0, '0, '0);
        send_word(OP_TICK, '0, '0, '0);
        // Full-range call, and a zero delay that leaves a call inactive.
        send_word(OP_SET_CALL, 3'd3, 16'hFFFF, 16'hFFFF);
        send_word(OP_SET_CALL, 3'd5, 16'd0, 16'd7);
        send_word(OP_TICK, '0, '0, '0);
        send_word(OP_SET_ONE, 3'd7, 16'd0, '0);
        send_word(OP_READ_ONE, 3'd7, '0, '0);

        // Random part, with a stretch of back-to-back traffic in the middle
        // and a few full drains along the way.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150)
                steady_mode <= 1'b1;
            if (n == 260)
                steady_mode <= 1'b0;
            if (n % 90 == 45)
                wait_drained();
            send_random_word();
        end

        // Wait out the remaining words, then keep the clock running for any stray one.
        wait_drained();
        repeat (NUM_CALLS + 4) @(posedge i_clk);

        if (mismatch_total == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
